/* rtl/met_pkg.sv */
// Shared types, widths, constants and helpers for the Mandelbrot escape-time pixel engine.
`default_nettype none

package met_pkg;

    localparam int FRAC      = 28;
    localparam int Q_W       = 32;   // Q4.28 point and iterate width
    localparam int MW        = 33;   // multiplier operand width
    localparam int PW        = 66;   // multiplier product width
    localparam int SW        = 68;   // sum width
    localparam int IN_W      = 12;
    localparam int ITER_W    = 25;
    localparam int STEP_W    = 28;
    localparam int CFG_W     = 28;
    localparam int CFG_AW    = 2;
    localparam int RAD_W     = 64;
    localparam int QD_W      = 56;
    localparam int R_W       = 32;
    localparam int CNT_W     = 6;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 56;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam int MAX_DIM_DEF = 4096;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 25'd524288;
    localparam logic [STEP_W-1:0] X_STEP_RST   = 28'd1007893;
    localparam logic [STEP_W-1:0] Y_STEP_RST   = 28'd1008314;

    localparam logic [CFG_AW-1:0] REG_MAX_ITER = 2'd0;
    localparam logic [CFG_AW-1:0] REG_X_STEP   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_Y_STEP   = 2'd2;

    localparam logic signed [SW-1:0] RE0      = -68'sd536870912;
    localparam logic signed [SW-1:0] IM0      = -68'sd301989888;
    localparam logic signed [SW-1:0] DISK_LIM = 68'sd4503599627370496;
    localparam logic signed [SW-1:0] ESC_LIM  = 68'sd288230376151711744;
    localparam logic signed [MW-1:0] ONE_M    = 33'sd268435456;
    localparam logic signed [MW-1:0] QUART_M  = 33'sd67108864;
    localparam logic signed [Q_W-1:0] CARD_LO = -32'sd201326592;
    localparam logic signed [Q_W-1:0] CARD_HI = 32'sd134217728;
    localparam logic signed [30:0]    H_ONE   = 31'sd268435456;

    localparam logic [RAD_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } rd_mode_t;

    typedef struct packed {
        logic     start;
        rd_mode_t mode;
    } rd_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CR,
        ST_CI,
        ST_SQR,
        ST_SQI,
        ST_SQ1,
        ST_SQT,
        ST_CARD,
        ST_ROOT,
        ST_DIV,
        ST_ITER_A,
        ST_ITER_B,
        ST_ITER_C,
        ST_ITER_D,
        ST_DONE
    } state_t;

    // clamp a wide signed sum to the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SW-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[SW-1:Q_W-1] == '0 || v[SW-1:Q_W-1] == '1) begin
            r = v[Q_W-1:0];
        end else if (v[SW-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mandelbrot_escape_time_pixel.sv */
// Top level: Mandelbrot escape-time pixel engine with sequencer and config registers.
//
// Input stream s_*: one word per pixel, column in tdata[11:0], row in tdata[23:12].
// Output stream m_*: one word per pixel, iteration count in tdata[24:0].
// Config port: cfg_wr_en/cfg_addr/cfg_wdata write max_iter (0), x_step (1), y_step (2);
// other indexes are ignored. Write only while no pixel is in flight.
// One pixel at a time: s_tready is high only while the sequencer is idle.
// All products go through one registered 33x33 multiplier; the cardioid check uses
// one iterative root/divide unit (32 root steps, 56 divide steps).
// A pixel ends with count max_iter when c falls in either disk or when the cardioid
// check finds it inside; otherwise it iterates until escape or max_iter. The cardioid
// check runs only when c lies in the cardioid band, and a zero root skips the divide.
// At the earliest, s_tready rises together with m_tvalid.
// The output word sits in a register; the next pixel is taken while it waits, and
// a finished pixel holds in the done state until that register is free.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops m_tvalid and
// loads the default max_iter, x_step and y_step.
`default_nettype none

module mandelbrot_escape_time_pixel #(
    parameter int MAX_DIM = met_pkg::MAX_DIM_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [met_pkg::S_TDATA_W-1:0]     s_tdata,   // column[11:0], row[23:12]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [met_pkg::M_TDATA_W-1:0]          m_tdata,   // iteration_count[24:0]
    input  wire logic                              cfg_wr_en,
    input  wire logic [met_pkg::CFG_AW-1:0]        cfg_addr,
    input  wire logic [met_pkg::CFG_W-1:0]         cfg_wdata
);
    import met_pkg::*;

    localparam int unsigned DIM_LIM = MAX_DIM - 1;

    state_t state_reg, state_next;

    logic [ITER_W-1:0] max_iter_reg;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;

    logic [IN_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic signed [Q_W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [Q_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [PW-1:0]  acc_reg, acc_next, ci2_reg, ci2_next;
    logic signed [SW-1:0]  diff_reg, diff_next;
    logic              inside_reg, inside_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic [ITER_W-1:0] n_reg, n_next;
    logic [ITER_W-1:0] count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [ITER_W-1:0] m_data_reg, m_data_next;

    logic [IN_W-1:0]   s_col, s_row, col_clamp, row_clamp;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [MW-1:0] cr_ext, cr1, t_val, t_mag;
    logic              t_neg, in_band;
    logic signed [SW-1:0] sum_p, sum_c;
    logic [QD_W-1:0]   dividend;
    logic signed [30:0] q_s, h_val, h_half;

    rd_ctrl_t          rd_ctrl;
    logic [RAD_W-1:0]  rd_operand;
    logic [R_W-1:0]    rd_divisor;
    logic              rd_done;
    logic [QD_W-1:0]   rd_result;

    assign s_col     = s_tdata[IN_W-1:0];
    assign s_row     = s_tdata[2*IN_W-1:IN_W];
    assign col_clamp = (32'(s_col) > DIM_LIM) ? IN_W'(DIM_LIM) : s_col;
    assign row_clamp = (32'(s_row) > DIM_LIM) ? IN_W'(DIM_LIM) : s_row;

    assign cr_ext   = {cr_reg[Q_W-1], cr_reg};
    assign cr1      = cr_ext + ONE_M;
    assign t_val    = cr_ext - QUART_M;
    assign t_neg    = t_val[MW-1];
    assign t_mag    = t_neg ? -t_val : t_val;
    assign in_band  = (cr_reg > CARD_LO) && (cr_reg < CARD_HI);
    assign dividend = {t_mag[FRAC-1:0], {FRAC{1'b0}}};
    assign sum_p    = SW'(acc_reg) + SW'(prod);
    assign sum_c    = SW'(ci2_reg) + SW'(prod);

    assign q_s    = t_neg ? -{2'b00, rd_result[FRAC:0]} : {2'b00, rd_result[FRAC:0]};
    assign h_val  = H_ONE - q_s;
    assign h_half = h_val >>> 1;

    met_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    met_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rd_ctrl),
        .operand (rd_operand),
        .divisor (rd_divisor),
        .done    (rd_done),
        .result  (rd_result)
    );

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cr_next       = cr_reg;
        ci_next       = ci_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        acc_next      = acc_reg;
        ci2_next      = ci2_reg;
        diff_next     = diff_reg;
        inside_next   = inside_reg;
        r_next        = r_reg;
        n_next        = n_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        mul_a         = '0;
        mul_b         = '0;
        rd_ctrl.start = 1'b0;
        rd_ctrl.mode  = RD_SQRT;
        rd_operand    = sum_c[RAD_W-1:0];
        rd_divisor    = rd_result[R_W-1:0];
        s_tready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    col_next   = col_clamp;
                    row_next   = row_clamp;
                    zr_next    = '0;
                    zi_next    = '0;
                    n_next     = '0;
                    state_next = ST_CR;
                end
            end
            ST_CR: begin
                mul_a      = $signed({{(MW-IN_W){1'b0}}, col_reg});
                mul_b      = $signed({{(MW-STEP_W){1'b0}}, x_step_reg});
                state_next = ST_CI;
            end
            ST_CI: begin
                cr_next    = sat_q(SW'(prod) + RE0);
                mul_a      = $signed({{(MW-IN_W){1'b0}}, row_reg});
                mul_b      = $signed({{(MW-STEP_W){1'b0}}, y_step_reg});
                state_next = ST_SQR;
            end
            ST_SQR: begin
                ci_next    = sat_q(SW'(prod) + IM0);
                mul_a      = cr_ext;
                mul_b      = cr_ext;
                state_next = ST_SQI;
            end
            ST_SQI: begin
                acc_next   = prod;
                mul_a      = {ci_reg[Q_W-1], ci_reg};
                mul_b      = {ci_reg[Q_W-1], ci_reg};
                state_next = ST_SQ1;
            end
            ST_SQ1: begin
                ci2_next    = prod;
                inside_next = (sum_p < DISK_LIM);
                mul_a       = cr1;
                mul_b       = cr1;
                state_next  = ST_SQT;
            end
            ST_SQT: begin
                inside_next = inside_reg || (sum_c < DISK_LIM);
                mul_a       = t_val;
                mul_b       = t_val;
                state_next  = ST_CARD;
            end
            ST_CARD: begin
                if (inside_reg) begin
                    count_next = max_iter_reg;
                    state_next = ST_DONE;
                end else if (in_band) begin
                    rd_ctrl.start = 1'b1;
                    rd_ctrl.mode  = RD_SQRT;
                    state_next    = ST_ROOT;
                end else begin
                    state_next = ST_ITER_A;
                end
            end
            ST_ROOT: begin
                rd_operand = {{(RAD_W-QD_W){1'b0}}, dividend};
                if (rd_done) begin
                    r_next = rd_result[R_W-1:0];
                    if (rd_result[R_W-1:0] == '0) begin
                        state_next = ST_ITER_A;
                    end else begin
                        rd_ctrl.start = 1'b1;
                        rd_ctrl.mode  = RD_DIV;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (rd_done) begin
                    if ($signed({1'b0, r_reg}) < MW'(h_half)) begin
                        count_next = max_iter_reg;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ITER_A;
                    end
                end
            end
            ST_ITER_A: begin
                mul_a      = {zr_reg[Q_W-1], zr_reg};
                mul_b      = {zr_reg[Q_W-1], zr_reg};
                state_next = ST_ITER_B;
            end
            ST_ITER_B: begin
                acc_next   = prod;
                mul_a      = {zi_reg[Q_W-1], zi_reg};
                mul_b      = {zi_reg[Q_W-1], zi_reg};
                state_next = ST_ITER_C;
            end
            ST_ITER_C: begin
                diff_next = SW'(acc_reg) - SW'(prod);
                mul_a     = {zr_reg[Q_W-1], zr_reg};
                mul_b     = {zi_reg[Q_W-1], zi_reg};
                if (sum_p >= ESC_LIM || n_reg >= max_iter_reg) begin
                    count_next = n_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ITER_D;
                end
            end
            ST_ITER_D: begin
                zr_next    = sat_q((diff_reg >>> FRAC) + SW'(cr_reg));
                zi_next    = sat_q((SW'(prod) >>> (FRAC - 1)) + SW'(ci_reg));
                n_next     = n_reg + 1'b1;
                state_next = ST_ITER_A;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            max_iter_reg <= MAX_ITER_RST;
            x_step_reg   <= X_STEP_RST;
            y_step_reg   <= Y_STEP_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MAX_ITER: max_iter_reg <= cfg_wdata[ITER_W-1:0];
                    REG_X_STEP:   x_step_reg   <= cfg_wdata[STEP_W-1:0];
                    REG_Y_STEP:   y_step_reg   <= cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        acc_reg    <= acc_next;
        ci2_reg    <= ci2_next;
        diff_reg   <= diff_next;
        inside_reg <= inside_next;
        r_reg      <= r_next;
        n_reg      <= n_next;
        count_reg  <= count_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-ITER_W){1'b0}}, m_data_reg};

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while a pixel is in flight");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside the done state");

    a_unit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ctrl.start |-> (state_reg == ST_CARD || state_reg == ST_ROOT))
        else $error("root/divide unit started out of sequence");

    a_iter_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ITER_D) |=> (n_reg == $past(n_reg) + 25'd1))
        else $error("iteration count did not advance");

endmodule

`default_nettype wire

/* rtl/met_mul.sv */
// Shared registered signed multiplier.
`default_nettype none

module met_mul (
    input  wire logic                         aclk,
    input  wire logic signed [met_pkg::MW-1:0] op_a,
    input  wire logic signed [met_pkg::MW-1:0] op_b,
    output logic signed [met_pkg::PW-1:0]      prod
);
    import met_pkg::*;

    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/met_root_div.sv */
// Iterative unit: bit-pair integer square root and restoring division.
`default_nettype none

module met_root_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire met_pkg::rd_ctrl_t           ctrl,
    input  wire logic [met_pkg::RAD_W-1:0]   operand,
    input  wire logic [met_pkg::R_W-1:0]     divisor,
    output logic                             done,
    output logic [met_pkg::QD_W-1:0]         result
);
    import met_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    rd_mode_t         mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0] v_reg, v_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [R_W-1:0]   dvs_reg, dvs_next;

    logic [RAD_W-1:0] root_trial;
    logic [R_W+1:0]   div_trial;

    assign root_trial = res_reg + bit_reg;
    assign div_trial  = {1'b0, res_reg[R_W-1:0], v_reg[QD_W-1]} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            mode_next = ctrl.mode;
            v_next    = operand;
            res_next  = '0;
            bit_next  = SQRT_BIT0;
            dvs_next  = divisor;
            cnt_next  = (ctrl.mode == RD_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
        end else if (busy_reg) begin
            case (mode_reg)
                RD_SQRT: begin
                    if (v_reg >= root_trial) begin
                        v_next   = v_reg - root_trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end else begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                RD_DIV: begin
                    if (!div_trial[R_W+1]) begin
                        res_next = {{(RAD_W-R_W){1'b0}}, div_trial[R_W-1:0]};
                    end else begin
                        res_next = {{(RAD_W-R_W){1'b0}}, res_reg[R_W-2:0], v_reg[QD_W-1]};
                    end
                    v_next = {{(RAD_W-QD_W){1'b0}}, v_reg[QD_W-2:0], ~div_trial[R_W+1]};
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        dvs_reg  <= dvs_next;
    end

    assign done   = done_reg;
    assign result = (mode_reg == RD_SQRT) ? res_reg[QD_W-1:0] : v_reg[QD_W-1:0];

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Testbench for the Mandelbrot escape-time pixel engine: predicted iteration counts versus stream output.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int          STALL_LIMIT = 6000;
    localparam int          QUICK_ITERS = 64;
    localparam int          FRAC_BITS   = 28;
    localparam longint      Q_ONE       = 64'sd1 << FRAC_BITS;
    localparam longint      Q_HI        = 64'sd2147483647;
    localparam longint      Q_LO        = -64'sd2147483648;
    localparam longint      BAND_LO     = -(3 * Q_ONE) / 4;
    localparam longint      BAND_HI     = Q_ONE / 2;
    localparam longint unsigned DISK_R2   = 64'd1 << 52;
    localparam longint unsigned ESCAPE_R2 = 64'd4 << 56;
    localparam logic [STEP_W-1:0] GRID_STEP = 28'd1048576;  // 1/256 per pixel
    localparam logic [CFG_W-1:0]  STEP_MAX  = 28'hFFF_FFFF;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]     cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    logic [ITER_W-1:0] limit_reg = 25'd524288;
    logic [STEP_W-1:0] xstep_reg = 28'd1007893;
    logic [STEP_W-1:0] ystep_reg = 28'd1008314;

    logic [ITER_W-1:0] pending_counts[$];
    int mismatches  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    mandelbrot_escape_time_pixel dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // column[11:0], row[23:12]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // iteration_count[24:0]
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic longint unsigned mag2(input longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    // captured: point judged inside by the disk or cardioid shortcut
    function automatic logic [ITER_W-1:0] escape_count(
        input  logic [IN_W-1:0]   col,
        input  logic [IN_W-1:0]   row,
        input  logic [ITER_W-1:0] limit,
        input  logic [STEP_W-1:0] xs,
        input  logic [STEP_W-1:0] ys,
        output bit                captured
    );
        longint cr, ci, zr, zi, nr, ni, t, q, h;
        longint unsigned rad2, root, bitv, mag;
        logic [ITER_W-1:0] n;
        captured = 1'b0;
        n = '0;
        zr = 0;
        zi = 0;
        cr = clamp_q(-2 * Q_ONE + longint'(col) * longint'(xs));
        ci = clamp_q(-(9 * Q_ONE) / 8 + longint'(row) * longint'(ys));
        if (mag2(cr) + mag2(ci) < DISK_R2 || mag2(cr + Q_ONE) + mag2(ci) < DISK_R2) begin
            captured = 1'b1;
        end else if (cr > BAND_LO && cr < BAND_HI) begin
            t = cr - Q_ONE / 4;
            rad2 = mag2(t) + mag2(ci);
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rad2) bitv >>= 2;
            while (bitv != 0) begin
                if (rad2 >= root + bitv) begin
                    rad2 -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            if (root != 0) begin
                mag = (t < 0) ? -t : t;
                q = longint'((mag << FRAC_BITS) / root);
                if (t < 0) q = -q;
                h = (Q_ONE - q) >>> 1;
                captured = longint'(root) < h;
            end
        end
        if (captured) return limit;
        while (mag2(zr) + mag2(zi) < ESCAPE_R2 && n < limit) begin
            nr = clamp_q(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
            ni = clamp_q(((2 * zr * zi) >>> FRAC_BITS) + ci);
            zr = nr;
            zi = ni;
            n++;
        end
        return n;
    endfunction

    // true when the pixel finishes fast under the current settings
    function automatic bit is_quick(input logic [IN_W-1:0] col, input logic [IN_W-1:0] row);
        bit bulb;
        logic [ITER_W-1:0] n;
        n = escape_count(col, row, ITER_W'(QUICK_ITERS), xstep_reg, ystep_reg, bulb);
        return bulb || n < QUICK_ITERS;
    endfunction

    task automatic report_mismatch(input string what, input logic [ITER_W-1:0] want,
                                   input logic [ITER_W-1:0] got);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    task automatic send_pixel(input logic [IN_W-1:0] col, input logic [IN_W-1:0] row);
        bit bulb;
        int gap;
        pending_counts.push_back(escape_count(col, row, limit_reg, xstep_reg, ystep_reg, bulb));
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MAX_ITER: limit_reg = value[ITER_W-1:0];
            REG_X_STEP:   xstep_reg = value[STEP_W-1:0];
            REG_Y_STEP:   ystep_reg = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_reset_defaults;
        if (is_quick(12'd0, 12'd0))       send_pixel(12'd0, 12'd0);
        if (is_quick(12'd533, 12'd300))   send_pixel(12'd533, 12'd300);
        if (is_quick(12'd266, 12'd300))   send_pixel(12'd266, 12'd300);
        if (is_quick(12'd453, 12'd379))   send_pixel(12'd453, 12'd379);
        if (is_quick(12'd4095, 12'd4095)) send_pixel(12'd4095, 12'd4095);
    endtask

    // steps of 1/256 put pixels exactly on the disk, band and cardioid edges
    task automatic check_grid_edges;
        write_reg(REG_MAX_ITER, 28'd40);
        write_reg(REG_X_STEP, GRID_STEP);
        write_reg(REG_Y_STEP, GRID_STEP);
        send_pixel(12'd576, 12'd288);   // cardioid cusp, zero radius
        send_pixel(12'd320, 12'd288);
        send_pixel(12'd321, 12'd288);
        send_pixel(12'd640, 12'd288);
        send_pixel(12'd639, 12'd288);
        send_pixel(12'd512, 12'd288);
        send_pixel(12'd256, 12'd288);
        send_pixel(12'd512, 12'd352);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd2730, 12'd1365);
        send_pixel(12'd1365, 12'd2730);
    endtask

    task automatic check_zero_limit;
        write_reg(REG_MAX_ITER, 28'd0);
        send_pixel(12'd512, 12'd288);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd576, 12'd288);
    endtask

    task automatic check_step_extremes;
        write_reg(REG_MAX_ITER, 28'd1);
        write_reg(REG_X_STEP, 28'd0);
        write_reg(REG_Y_STEP, STEP_MAX);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd100, 12'd1);
        write_reg(REG_MAX_ITER, 28'd30);
        write_reg(REG_X_STEP, STEP_MAX);
        write_reg(REG_Y_STEP, 28'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2, 12'd5);
    endtask

    // huge limits: only pixels that are captured or escape early
    task automatic check_large_limits;
        int sent;
        int pass;
        logic [IN_W-1:0] col, row;
        write_reg(REG_X_STEP, GRID_STEP);
        write_reg(REG_Y_STEP, GRID_STEP);
        for (pass = 0; pass < 2; pass++) begin
            if (pass == 0) begin
                write_reg(REG_MAX_ITER, 28'd16777216);
            end else begin
                write_reg(REG_MAX_ITER, STEP_MAX);       // upper bits dropped
                write_reg(REG_UNUSED, 28'($urandom));
            end
            sent = 0;
            while (sent < 40) begin
                if ($urandom_range(0, 3) == 0) begin
                    col = IN_W'($urandom);
                    row = IN_W'($urandom);
                end else begin
                    col = IN_W'($urandom_range(192, 704));
                    row = IN_W'($urandom_range(96, 480));
                end
                if (is_quick(col, row)) begin
                    send_pixel(col, row);
                    sent++;
                end
            end
        end
    endtask

    // mostly pixels inside a random image frame, some anywhere
    task automatic check_random_images;
        int phase, i, width, height;
        logic [IN_W-1:0] col, row;
        for (phase = 0; phase < 10; phase++) begin
            if (phase % 5 == 4) write_reg(REG_MAX_ITER, 28'($urandom_range(65, 128)));
            else                write_reg(REG_MAX_ITER, 28'($urandom_range(1, 64)));
            if ($urandom_range(0, 4) == 0) begin
                width  = 4096;
                height = 4096;
                write_reg(REG_X_STEP, 28'($urandom));
                write_reg(REG_Y_STEP, 28'($urandom));
            end else begin
                width  = $urandom_range(0, 1) ? $urandom_range(5, 64) : $urandom_range(5, 4096);
                height = $urandom_range(0, 1) ? $urandom_range(5, 64) : $urandom_range(5, 4096);
                write_reg(REG_X_STEP, 28'((64'd3 << 28) / (width - 1)));
                write_reg(REG_Y_STEP, 28'((64'd9 << 26) / (height - 1)));
            end
            for (i = 0; i < 200; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    col = IN_W'($urandom);
                    row = IN_W'($urandom);
                end else begin
                    col = IN_W'($urandom_range(0, width - 1));
                    row = IN_W'($urandom_range(0, height - 1));
                end
                send_pixel(col, row);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_left % 5) != 0;
        endcase
    end

    always @(posedge aclk) begin : check_results
        logic [ITER_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                report_mismatch("word with no pixel pending", '0, m_tdata[ITER_W-1:0]);
            end else begin
                want = pending_counts.pop_front();
                if (m_tdata[ITER_W-1:0] !== want)
                    report_mismatch("iteration_count", want, m_tdata[ITER_W-1:0]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        check_reset_defaults();
        check_grid_edges();
        check_zero_limit();
        check_step_extremes();
        check_large_limits();
        check_random_images();
        drain_results();
        repeat (400) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
